// ===== src/dmpi_pkg.sv =====
// dmpi_pkg: shared types, codes and saturating arithmetic for the delay model evaluator
// no dependencies; imported by every module of the block except dmpi_ram
`timescale 1ns / 1ps
`default_nettype none
package dmpi_pkg;

	// parameter defaults
	localparam int MAX_SCANS_DEF    = 4;
	localparam int MAX_SAMPLES_DEF  = 64;
	localparam int MAX_ANTENNAS_DEF = 16;
	localparam int MAX_SOURCES_DEF  = 4;
	localparam int MAX_TERMS_DEF    = 8;

	// fixed widths
	localparam int TERM_W    = 4;   // holds any term index up to 15
	localparam int TIME_W    = 41;  // offset plus span, q.24
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;

	// action codes
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_UVW   = 2'd1;
	localparam logic [1:0] ACT_DELAY = 2'd2;

	// quantities
	localparam logic [1:0] QTY_DELAY = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_UVW   = 2'd0;
	localparam logic [1:0] KIND_CONST = 2'd1;
	localparam logic [1:0] KIND_LIN   = 2'd2;
	localparam logic [1:0] KIND_QUAD  = 2'd3;

	// fit orders
	localparam logic [1:0] FIT_CONST = 2'd0;
	localparam logic [1:0] FIT_LIN   = 2'd1;
	localparam logic [1:0] FIT_QUAD  = 2'd2;
	localparam logic [1:0] FIT_BAD   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLY_ORDER = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 4'd1;

	localparam logic [2:0]  POLY_ORDER_RST = 3'd4;
	localparam logic [15:0] INTERVAL_RST   = 16'd120;

	localparam logic signed [67:0] S64_MAX = 68'sd9223372036854775807;
	localparam logic signed [67:0] S64_MIN = -68'sd9223372036854775808;

	typedef enum logic [2:0] {
		H_IDLE, H_FETCH, H_LOAD, H_CHK, H_MUL, H_ADD
	} hrn_state_t;

	typedef enum logic [1:0] {
		D_IDLE, D_RUN, D_FIX
	} div_state_t;

	typedef enum logic [4:0] {
		T_IDLE, T_SDIV_GO, T_SDIV_WAIT, T_BASE, T_TIME, T_EVAL_GO, T_EVAL_WAIT, T_FIT,
		L_DIFF, L_DIV1_GO, L_DIV1_WAIT, L_HALF, L_ENUM, L_DIV3_GO, L_DIV3_WAIT,
		Q_NUM2A, Q_NUM2B, Q_DIVA_GO, Q_DIVA_WAIT, Q_NUM1A, Q_NUM1B, Q_NUM1C,
		Q_DIVB_GO, Q_DIVB_WAIT, T_OUT
	} top_state_t;

	typedef struct packed {
		logic              start;
		logic [TERM_W-1:0] order;
		logic [TIME_W-1:0] t;
	} hrn_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] value;
	} hrn_rsp_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] dividend;
		logic [31:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] quot;
		logic signed [63:0] rem;
	} div_rsp_t;

	function automatic logic signed [63:0] sat64(input logic signed [67:0] x);
		logic signed [63:0] r;
		if (x > S64_MAX)
			r = S64_MAX[63:0];
		else if (x < S64_MIN)
			r = S64_MIN[63:0];
		else
			r = x[63:0];
		return r;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		return sat64(68'(a) + 68'(b));
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		return sat64(68'(a) - 68'(b));
	endfunction

	function automatic logic signed [63:0] mul2(input logic signed [63:0] a);
		return sat64(68'(a) <<< 1);
	endfunction

	function automatic logic signed [63:0] mul3(input logic signed [63:0] a);
		return sat64((68'(a) <<< 1) + 68'(a));
	endfunction

	function automatic logic signed [63:0] mul4(input logic signed [63:0] a);
		return sat64(68'(a) <<< 2);
	endfunction

endpackage
`default_nettype wire

// ===== src/dmpi_ram.sv =====
// dmpi_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module dmpi_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/dmpi_horner.sv =====
// dmpi_horner: horner evaluator, one term per pass, 4-step split multiplier
// depends on dmpi_pkg; reads coefficients through the ram read port of the top
`timescale 1ns / 1ps
`default_nettype none
module dmpi_horner (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dmpi_pkg::hrn_req_t        req,
	input  wire logic signed [63:0]        coef,
	output logic [dmpi_pkg::TERM_W-1:0]    term,
	output dmpi_pkg::hrn_rsp_t             rsp
);
	import dmpi_pkg::*;

	hrn_state_t         st_q, st_d;
	logic [TERM_W-1:0]  term_q;
	logic signed [63:0] acc_q;
	logic [63:0]        mag_q;
	logic               neg_q;
	logic [TIME_W-1:0]  t_q;
	logic [1:0]         step_q;
	logic [104:0]       prod_q;
	logic               done_q;

	logic [31:0]        mh, th;
	logic [63:0]        pp;
	logic [104:0]       pp_sh;
	logic [80:0]        r_full;
	logic signed [63:0] mt;

	// partial product: step bit 1 picks the acc half, bit 0 the time half
	always_comb begin
		mh = step_q[1] ? mag_q[63:32] : mag_q[31:0];
		th = step_q[0] ? 32'(t_q[TIME_W-1:32]) : t_q[31:0];
		pp = {32'b0, mh} * {32'b0, th};
		case (step_q)
			2'd0:    pp_sh = 105'(pp);
			2'd3:    pp_sh = {41'(pp), 64'b0};
			default: pp_sh = 105'({pp, 32'b0});
		endcase
	end

	// product shifted by 24, truncated toward zero and saturated
	always_comb begin
		r_full = prod_q[104:24];
		if (|r_full[80:64])
			mt = neg_q ? S64_MIN[63:0] : S64_MAX[63:0];
		else if (neg_q)
			mt = (r_full[63:0] > 64'h8000_0000_0000_0000) ? S64_MIN[63:0] :
				-$signed(r_full[63:0]);
		else
			mt = r_full[63] ? S64_MAX[63:0] : $signed(r_full[63:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			H_IDLE:  if (req.start) st_d = H_FETCH;
			H_FETCH: st_d = H_LOAD;
			H_LOAD:  st_d = H_CHK;
			H_CHK:   st_d = (term_q == '0) ? H_IDLE : H_MUL;
			H_MUL:   if (step_q == 2'd3) st_d = H_ADD;
			H_ADD:   st_d = H_CHK;
			default: st_d = H_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == H_CHK) && (term_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			H_IDLE: begin
				if (req.start) begin
					term_q <= req.order;
					t_q    <= req.t;
				end
			end
			H_LOAD: acc_q <= coef;
			H_CHK: begin
				if (term_q != '0) begin
					term_q <= term_q - 1'b1;
					neg_q  <= acc_q[63];
					mag_q  <= acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
					prod_q <= '0;
					step_q <= 2'd0;
				end
			end
			H_MUL: begin
				prod_q <= prod_q + pp_sh;
				step_q <= step_q + 1'b1;
			end
			H_ADD: acc_q <= sat_add(mt, coef);
			default: ;
		endcase
	end

	assign term      = term_q;
	assign rsp.done  = done_q;
	assign rsp.value = acc_q;
endmodule
`default_nettype wire

// ===== src/dmpi_div.sv =====
// dmpi_div: signed by unsigned radix-2 restoring divider, truncates toward zero
// depends on dmpi_pkg
`timescale 1ns / 1ps
`default_nettype none
module dmpi_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dmpi_pkg::div_req_t req,
	output dmpi_pkg::div_rsp_t      rsp
);
	import dmpi_pkg::*;

	div_state_t         st_q, st_d;
	logic [63:0]        num_q;
	logic [32:0]        rem_q;
	logic [31:0]        den_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic               done_q;
	logic signed [63:0] quot_q, remo_q;
	logic [32:0]        rem_sh;
	logic               fits;

	assign rem_sh = {rem_q[31:0], num_q[63]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == D_FIX);
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			D_IDLE:  if (req.start) st_d = D_RUN;
			D_RUN:   if (cnt_q == 6'd63) st_d = D_FIX;
			D_FIX:   st_d = D_IDLE;
			default: st_d = D_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (req.start) begin
					neg_q <= req.dividend[63];
					num_q <= req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
					den_q <= req.divisor;
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			D_RUN: begin
				rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
				num_q <= {num_q[62:0], fits};
				cnt_q <= cnt_q + 1'b1;
			end
			D_FIX: begin
				quot_q <= neg_q ? -$signed(num_q) : $signed(num_q);
				remo_q <= neg_q ? -$signed(64'(rem_q[31:0])) : $signed(64'(rem_q[31:0]));
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = remo_q;
endmodule
`default_nettype wire

// ===== src/delay_model_poly_interpolator.sv =====
// delay_model_poly_interpolator: coefficient store with polynomial uvw and delay-fit queries
// depends on dmpi_pkg, dmpi_ram, dmpi_horner, dmpi_div
// load item: written into the ram at the accepting edge, next item at once
// query: sample divide (64 serial steps), then one horner pass per polynomial
// delay linear fit adds a divide and a shift-add divide by three
// quadratic adds two divides plus the numerator steps; one item at a time
// reset clears control state and the config registers; the coefficient ram and datapath are not cleared
`timescale 1ns / 1ps
`default_nettype none
module delay_model_poly_interpolator #(
	parameter int MAX_SCANS    = dmpi_pkg::MAX_SCANS_DEF,
	parameter int MAX_SAMPLES  = dmpi_pkg::MAX_SAMPLES_DEF,
	parameter int MAX_ANTENNAS = dmpi_pkg::MAX_ANTENNAS_DEF,
	parameter int MAX_SOURCES  = dmpi_pkg::MAX_SOURCES_DEF,
	parameter int MAX_TERMS    = dmpi_pkg::MAX_TERMS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [dmpi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dmpi_pkg::CFG_DAT_W-1:0]    cfg_data,
	// input item channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        action,
	input  wire logic [1:0]                        scan_index,
	input  wire logic [5:0]                        sample_index,
	input  wire logic [3:0]                        antenna_index,
	input  wire logic [1:0]                        source_index,
	input  wire logic [1:0]                        quantity,
	input  wire logic [2:0]                        term_index,
	input  wire logic signed [63:0]                coefficient,
	input  wire logic [39:0]                       offset_time,
	input  wire logic [31:0]                       time_span,
	input  wire logic [15:0]                       increments,
	input  wire logic [1:0]                        fit_order,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [1:0]                             result_kind,
	output logic signed [63:0]                     value_a,
	output logic signed [63:0]                     value_b,
	output logic signed [63:0]                     value_c,
	output logic                                   bad_order,
	output logic                                   out_of_range
);
	import dmpi_pkg::*;

	// address fields, packed at power-of-two strides
	localparam int SCN_W  = (MAX_SCANS > 1) ? $clog2(MAX_SCANS) : 1;
	localparam int SMP_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int ANT_W  = $clog2(MAX_ANTENNAS);
	localparam int SRC_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int TRM_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int ADDR_W = SCN_W + SMP_W + ANT_W + SRC_W + 2 + TRM_W;
	localparam int DEPTH  = 2 ** ADDR_W;

	function automatic logic [ADDR_W-1:0] pack_addr(input logic [15:0] scn,
		input logic [15:0] smp, input logic [15:0] ant, input logic [15:0] src,
		input logic [15:0] qty, input logic [15:0] trm);
		return {scn[SCN_W-1:0], smp[SMP_W-1:0], ant[ANT_W-1:0], src[SRC_W-1:0],
			qty[1:0], trm[TRM_W-1:0]};
	endfunction

	// configuration registers
	logic [2:0]  poly_order_q;
	logic [15:0] interval_q;
	logic [15:0] ivl_eff;
	logic [TERM_W-1:0] order_eff;

	assign cfg_ready = 1'b1;
	assign ivl_eff   = (interval_q == '0) ? 16'd1 : interval_q;
	assign order_eff = (32'(poly_order_q) > MAX_TERMS - 1) ? TERM_W'(MAX_TERMS - 1) :
		TERM_W'(poly_order_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_order_q <= POLY_ORDER_RST;
			interval_q   <= INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POLY_ORDER: poly_order_q <= cfg_data[2:0];
				REG_INTERVAL:   interval_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state
	top_state_t state_q, state_d;
	logic       in_acc;

	// query context
	logic [1:0]         scan_q, src_q;
	logic [3:0]         ant_q;
	logic [39:0]        offs_q;
	logic [31:0]        span_q;
	logic [15:0]        n_q;
	logic [31:0]        nsq_q;
	logic [1:0]         ford_q;
	logic               dly_q, ok_q, bad_q, oor_q;
	logic [SMP_W-1:0]   sample_q;
	logic [TIME_W-1:0]  base_q, t0_q, tm_q, te_q;
	logic [1:0]         ev_q;
	logic signed [63:0] res_q [3];
	logic signed [63:0] x_q, y_q, z_q;
	logic signed [63:0] va_q, vb_q, vc_q;
	logic [1:0]         kind_q;
	logic [SMP_W+15:0]  sprod;
	logic signed [63:0] d0, d1, d2;
	logic               last_ev;

	assign d1 = res_q[0];
	assign d0 = res_q[1];
	assign d2 = res_q[2];
	assign last_ev = dly_q ? ((ford_q == FIT_CONST) || (ev_q == 2'd2)) : (ev_q == 2'd2);

	assign in_stall = (state_q != T_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// coefficient memory: loads write straight from the accepted item
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [63:0]       rdata;
	logic signed [63:0] coef_rd;

	assign we = in_acc && (action == ACT_LOAD) &&
		(32'(scan_index) < MAX_SCANS) && (32'(sample_index) < MAX_SAMPLES) &&
		(32'(antenna_index) < MAX_ANTENNAS) && (32'(source_index) < MAX_SOURCES) &&
		(32'(term_index) < MAX_TERMS);
	assign waddr = pack_addr(16'(scan_index), 16'(sample_index), 16'(antenna_index),
		16'(source_index), 16'(quantity), 16'(term_index));

	dmpi_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (coefficient),
		.raddr (raddr),
		.rdata (rdata)
	);

	// out-of-range query addresses read as zero
	assign coef_rd = ok_q ? $signed(rdata) : 64'sd0;

	// horner unit
	hrn_req_t          h_req;
	hrn_rsp_t          h_rsp;
	logic [TERM_W-1:0] h_term;
	logic [1:0]        q_sel;

	dmpi_horner u_horner (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (h_req),
		.coef   (coef_rd),
		.term   (h_term),
		.rsp    (h_rsp)
	);

	// uvw uses quantity = eval index; delay evaluates middle, start, end (only middle for a constant fit)
	always_comb begin
		q_sel       = dly_q ? QTY_DELAY : ev_q;
		h_req.start = (state_q == T_EVAL_GO);
		h_req.order = order_eff;
		if (!dly_q)
			h_req.t = t0_q;
		else begin
			case (ev_q)
				2'd0:    h_req.t = tm_q;
				2'd1:    h_req.t = t0_q;
				default: h_req.t = te_q;
			endcase
		end
	end

	assign raddr = pack_addr(16'(scan_q), 16'(sample_q), 16'(ant_q), 16'(src_q),
		16'(q_sel), 16'(h_term));

	// shared divider
	div_req_t d_req;
	div_rsp_t d_rsp;

	dmpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (d_req),
		.rsp    (d_rsp)
	);

	always_comb begin
		d_req.start    = 1'b0;
		d_req.dividend = x_q;
		d_req.divisor  = 32'(n_q);
		case (state_q)
			T_SDIV_GO: begin
				d_req.start    = 1'b1;
				d_req.dividend = 64'(offs_q[39:24]);
				d_req.divisor  = 32'(ivl_eff);
			end
			L_DIV1_GO, Q_DIVB_GO: d_req.start = 1'b1;
			Q_DIVA_GO: begin
				d_req.start   = 1'b1;
				d_req.divisor = nsq_q;
			end
			default: ;
		endcase
	end

	// divide by three for the intercept: shift-add estimate of the magnitude,
	// then one fix from the small remainder, sign put back at the end
	logic [63:0]        d3_n_q, d3_e_q, d3_mag;
	logic [2:0]         d3_step_q;
	logic               d3_neg_q, d3_done;
	logic signed [63:0] d3_quot;

	assign d3_mag  = x_q[63] ? 64'(-x_q) : 64'(x_q);
	assign d3_done = (d3_step_q == 3'd7);
	assign d3_quot = d3_neg_q ? -$signed(d3_e_q) : $signed(d3_e_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d3_step_q <= '0;
		end else if (state_q == L_DIV3_GO) begin
			d3_step_q <= 3'd1;
		end else if (d3_step_q != '0) begin
			d3_step_q <= d3_step_q + 1'b1;   // wraps back to idle after done
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_DIV3_GO) begin
			d3_neg_q <= x_q[63];
			d3_n_q   <= d3_mag;
			d3_e_q   <= (d3_mag >> 2) + (d3_mag >> 4);
		end else begin
			case (d3_step_q)
				3'd1:    d3_e_q <= d3_e_q + (d3_e_q >> 4);
				3'd2:    d3_e_q <= d3_e_q + (d3_e_q >> 8);
				3'd3:    d3_e_q <= d3_e_q + (d3_e_q >> 16);
				3'd4:    d3_e_q <= d3_e_q + (d3_e_q >> 32);
				// remainder of the estimate, always small and non-negative
				3'd5:    d3_n_q <= d3_n_q - (d3_e_q + (d3_e_q << 1));
				3'd6:    d3_e_q <= d3_e_q + 64'(({d3_n_q[7:0], 3'b0} +
					{2'b0, d3_n_q[7:0], 1'b0} + 11'(d3_n_q[7:0])) >> 5);
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE: begin
				if (in_acc && ((action == ACT_UVW) || (action == ACT_DELAY)))
					state_d = T_SDIV_GO;
			end
			T_SDIV_GO:   state_d = T_SDIV_WAIT;
			T_SDIV_WAIT: if (d_rsp.done) state_d = T_BASE;
			T_BASE:      state_d = T_TIME;
			T_TIME:      state_d = T_EVAL_GO;
			T_EVAL_GO:   state_d = T_EVAL_WAIT;
			T_EVAL_WAIT: begin
				if (h_rsp.done)
					state_d = last_ev ? T_FIT : T_EVAL_GO;
			end
			T_FIT: begin
				if (!dly_q || (ford_q == FIT_CONST))
					state_d = T_OUT;
				else if (ford_q == FIT_QUAD)
					state_d = Q_NUM2A;
				else
					state_d = L_DIFF;
			end
			L_DIFF:      state_d = L_DIV1_GO;
			L_DIV1_GO:   state_d = L_DIV1_WAIT;
			L_DIV1_WAIT: if (d_rsp.done) state_d = L_HALF;
			L_HALF:      state_d = L_ENUM;
			L_ENUM:      state_d = L_DIV3_GO;
			L_DIV3_GO:   state_d = L_DIV3_WAIT;
			L_DIV3_WAIT: if (d3_done) state_d = T_OUT;
			Q_NUM2A:     state_d = Q_NUM2B;
			Q_NUM2B:     state_d = Q_DIVA_GO;
			Q_DIVA_GO:   state_d = Q_DIVA_WAIT;
			Q_DIVA_WAIT: if (d_rsp.done) state_d = Q_NUM1A;
			Q_NUM1A:     state_d = Q_NUM1B;
			Q_NUM1B:     state_d = Q_NUM1C;
			Q_NUM1C:     state_d = Q_DIVB_GO;
			Q_DIVB_GO:   state_d = Q_DIVB_WAIT;
			Q_DIVB_WAIT: if (d_rsp.done) state_d = T_OUT;
			T_OUT:       if (!out_stall) state_d = T_IDLE;
			default:     state_d = T_IDLE;
		endcase
	end

	assign sprod = (SMP_W + 16)'(sample_q) * (SMP_W + 16)'(ivl_eff);

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				if (in_acc) begin
					scan_q <= scan_index;
					ant_q  <= antenna_index;
					src_q  <= source_index;
					offs_q <= offset_time;
					span_q <= time_span;
					n_q    <= (increments == '0) ? 16'd1 : increments;
					dly_q  <= (action == ACT_DELAY);
					ok_q   <= (32'(scan_index) < MAX_SCANS) &&
						(32'(antenna_index) < MAX_ANTENNAS) &&
						(32'(source_index) < MAX_SOURCES);
					// an invalid fit order falls back to linear
					ford_q <= (fit_order == FIT_BAD) ? FIT_LIN : fit_order;
					bad_q  <= (action == ACT_DELAY) && (fit_order == FIT_BAD);
				end
			end
			T_SDIV_GO: nsq_q <= {16'b0, n_q} * {16'b0, n_q};
			T_SDIV_WAIT: begin
				if (d_rsp.done) begin
					// sample beyond the table clamps to the last one
					if (64'(d_rsp.quot) >= 64'(MAX_SAMPLES)) begin
						sample_q <= SMP_W'(MAX_SAMPLES - 1);
						oor_q    <= 1'b1;
					end else begin
						sample_q <= d_rsp.quot[SMP_W-1:0];
						oor_q    <= 1'b0;
					end
				end
			end
			T_BASE: base_q <= TIME_W'({sprod, 24'b0});
			T_TIME: begin
				t0_q <= TIME_W'(offs_q) - base_q;
				tm_q <= TIME_W'(offs_q) + TIME_W'(span_q >> 1) - base_q;
				te_q <= TIME_W'(offs_q) + TIME_W'(span_q) - base_q;
				ev_q <= 2'd0;
			end
			T_EVAL_WAIT: begin
				if (h_rsp.done) begin
					res_q[ev_q] <= h_rsp.value;
					ev_q        <= ev_q + 1'b1;
				end
			end
			T_FIT: begin
				if (!dly_q) begin
					kind_q <= KIND_UVW;
					va_q   <= res_q[0];
					vb_q   <= res_q[1];
					vc_q   <= res_q[2];
				end else if (ford_q == FIT_CONST) begin
					kind_q <= KIND_CONST;
					va_q   <= d1;
					vb_q   <= '0;
					vc_q   <= '0;
				end else if (ford_q == FIT_QUAD) begin
					kind_q <= KIND_QUAD;
				end else begin
					kind_q <= KIND_LIN;
				end
			end
			// linear: slope, then intercept from the midpoint residual
			L_DIFF: x_q <= sat_sub(d2, d0);
			L_DIV1_WAIT: begin
				if (d_rsp.done) begin
					va_q <= d_rsp.quot;
					y_q  <= x_q - d_rsp.rem;   // slope times increments, exact
				end
			end
			// halving truncated toward zero
			L_HALF: z_q <= sat_add($signed(y_q + 64'(y_q[63])) >>> 1, d0);
			L_ENUM: x_q <= sat_sub(d1, z_q);
			L_DIV3_WAIT: begin
				if (d3_done) begin
					vb_q <= sat_add(d0, d3_quot);
					vc_q <= '0;
				end
			end
			// quadratic
			Q_NUM2A: x_q <= sat_sub(mul2(d0), mul4(d1));
			Q_NUM2B: x_q <= sat_add(x_q, mul2(d2));
			Q_DIVA_WAIT: if (d_rsp.done) va_q <= d_rsp.quot;
			Q_NUM1A: z_q <= mul3(d0);
			Q_NUM1B: x_q <= sat_sub(mul4(d1), z_q);
			Q_NUM1C: x_q <= sat_sub(x_q, d2);
			Q_DIVB_WAIT: begin
				if (d_rsp.done) begin
					vb_q <= d_rsp.quot;
					vc_q <= d0;
				end
			end
			default: ;
		endcase
	end

	// result held until taken
	assign out_valid    = (state_q == T_OUT);
	assign result_kind  = kind_q;
	assign value_a      = va_q;
	assign value_b      = vb_q;
	assign value_c      = vc_q;
	assign bad_order    = bad_q;
	assign out_of_range = oor_q;
endmodule
`default_nettype wire

// ===== src/dmpi_checker.sv =====
// dmpi_checker: port-level assertions for the delay model evaluator, bound to the top
// depends on dmpi_pkg and delay_model_poly_interpolator
`timescale 1ns / 1ps
`default_nettype none
module dmpi_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [1:0]         result_kind,
	input wire logic signed [63:0] value_a,
	input wire logic signed [63:0] value_b,
	input wire logic signed [63:0] value_c,
	input wire logic               bad_order
);
	import dmpi_pkg::*;

	// result pending blocks new items
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("item accepted while result pending");

	// uvw results never flag a bad fit order
	a_uvw_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind == KIND_UVW)) |-> !bad_order)
		else $error("bad order flagged on uvw result");

	// constant fit leaves b and c clear
	a_const_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind == KIND_CONST)) |-> ((value_b == '0) && (value_c == '0)))
		else $error("constant fit with nonzero b or c");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(value_a) && $stable(result_kind)))
		else $error("stalled result changed");
endmodule

bind delay_model_poly_interpolator dmpi_checker u_dmpi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_kind (result_kind),
	.value_a     (value_a),
	.value_b     (value_b),
	.value_c     (value_c),
	.bad_order   (bad_order)
);
`default_nettype wire
